/* src/smd_pkg.sv */
`default_nettype none
package smd_pkg;

  localparam int unsigned PAYLOAD_DEPTH_DEF = 64;

  localparam logic [7:0] CMD_MIN     = 8'h80;
  localparam logic [7:0] START_SYSEX = 8'hF0;
  localparam logic [7:0] SYSEX_TERM  = 8'hF7;
  localparam logic [7:0] EXT_ID      = 8'h00;

  typedef enum logic [1:0] {
    KIND_STD   = 2'd0,
    KIND_SYSEX = 2'd1,
    KIND_EXT   = 2'd2
  } msg_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STD1,
    ST_STD2,
    ST_SXID,
    ST_EXLO,
    ST_EXHI,
    ST_DATA,
    ST_STD_OUT0,
    ST_STD_OUT1,
    ST_EMIT_RD,
    ST_EMIT_WR
  } parse_state_t;

  typedef struct packed {
    logic        valid;
    msg_kind_t   kind;
    logic [13:0] ident;
    logic [7:0]  data;
    logic        last;
    logic        trunc;
  } result_t;

endpackage
`default_nettype wire

/* src/smd_chan_if.sv */
`default_nettype none
interface smd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface smd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  msg_kind;
  logic [13:0] msg_ident;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        truncated;

  modport source (output valid, output msg_kind, output msg_ident, output data_byte,
                  output last_byte, output truncated, input ready);
  modport sink (input valid, input msg_kind, input msg_ident, input data_byte,
                input last_byte, input truncated, output ready);
endinterface
`default_nettype wire

/* src/sysex_message_deframer.sv */
`default_nettype none
// Channel   Direction  Payload
// in_ch     sink       in_byte (8)
// out_ch    source     msg_kind (2), msg_ident (14), data_byte (8), last_byte, truncated
//
// After an input byte that does not end a message, the parser is ready for the next one.
// Buffered sysex payload is read back from the payload memory, each byte by a read state
// and an emit state; a standard message puts out its two results; input waits meanwhile.
// Reset is synchronous and active low; it returns the parser to idle and empties the output.
// A full output register holds its result until taken, stalling only further results.
module sysex_message_deframer #(
  parameter int unsigned PAYLOAD_DEPTH = smd_pkg::PAYLOAD_DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  smd_in_if.sink   in_ch,
  smd_out_if.source out_ch
);
  import smd_pkg::*;

  result_t     push;
  logic        out_free;
  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [13:0] ident_r;
  logic [7:0]  data_r;
  logic        last_r;
  logic        trunc_r;

  assign out_free = !out_valid_r || out_ch.ready;

  smd_parser #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.in_byte),
    .in_ready (in_ch.ready),
    .out_free (out_free),
    .push     (push)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= push.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && push.valid) begin
      kind_r  <= push.kind;
      ident_r <= push.ident;
      data_r  <= push.data;
      last_r  <= push.last;
      trunc_r <= push.trunc;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.msg_kind  = kind_r;
  assign out_ch.msg_ident = ident_r;
  assign out_ch.data_byte = data_r;
  assign out_ch.last_byte = last_r;
  assign out_ch.truncated = trunc_r;

endmodule
`default_nettype wire

/* src/smd_payload_ram.sv */
`default_nettype none
module smd_payload_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* src/smd_parser.sv */
`default_nettype none
module smd_parser #(
  parameter int unsigned PAYLOAD_DEPTH = smd_pkg::PAYLOAD_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic [7:0]  in_byte,
  output logic             in_ready,
  input  wire logic        out_free,
  output smd_pkg::result_t push
);
  import smd_pkg::*;

  localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PAYLOAD_DEPTH + 1);

  parse_state_t  state_r, state_nxt;
  msg_kind_t     kind_r, kind_nxt;
  logic [13:0]   ident_r, ident_nxt;
  logic [7:0]    first_r, first_nxt;
  logic [7:0]    second_r, second_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] idx_r, idx_nxt;

  logic          acc;
  logic          wr_en;
  logic          rd_en;
  logic [7:0]    rd_data;
  logic          emit_last;

  smd_payload_ram #(
    .DEPTH (PAYLOAD_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_byte),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      kind_r  <= KIND_STD;
      ident_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      kind_r  <= kind_nxt;
      ident_r <= ident_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r  <= first_nxt;
    second_r <= second_nxt;
    idx_r    <= idx_nxt;
  end

  assign emit_last = ((CW'(idx_r) + CW'(1)) == count_r);

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    ident_nxt  = ident_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    idx_nxt    = idx_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    in_ready   = 1'b0;
    push       = '0;
    push.kind  = kind_r;
    push.ident = ident_r;

    case (state_r)
      ST_IDLE, ST_STD1, ST_STD2, ST_SXID, ST_EXLO, ST_EXHI, ST_DATA: in_ready = 1'b1;
      default: in_ready = 1'b0;
    endcase
    acc = in_valid && in_ready;

    case (state_r)
      ST_IDLE: begin
        if (acc && in_byte >= CMD_MIN && in_byte != SYSEX_TERM) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          if (in_byte == START_SYSEX) begin
            kind_nxt  = KIND_SYSEX;
            ident_nxt = '0;
            state_nxt = ST_SXID;
          end else begin
            kind_nxt  = KIND_STD;
            ident_nxt = {6'd0, in_byte};
            state_nxt = ST_STD1;
          end
        end
      end
      ST_STD1: begin
        if (acc) begin
          first_nxt = in_byte;
          state_nxt = ST_STD2;
        end
      end
      ST_STD2: begin
        if (acc) begin
          second_nxt = in_byte;
          state_nxt  = ST_STD_OUT0;
        end
      end
      ST_STD_OUT0: begin
        push.valid = 1'b1;
        push.data  = first_r;
        if (out_free) begin
          state_nxt = ST_STD_OUT1;
        end
      end
      ST_STD_OUT1: begin
        push.valid = 1'b1;
        push.data  = second_r;
        push.last  = 1'b1;
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SXID: begin
        if (acc) begin
          if (in_byte == EXT_ID) begin
            kind_nxt  = KIND_EXT;
            state_nxt = ST_EXLO;
          end else begin
            kind_nxt  = KIND_SYSEX;
            ident_nxt = {6'd0, in_byte};
            state_nxt = ST_DATA;
          end
        end
      end
      ST_EXLO: begin
        if (acc) begin
          ident_nxt = {7'd0, in_byte[6:0]};
          state_nxt = ST_EXHI;
        end
      end
      ST_EXHI: begin
        if (acc) begin
          ident_nxt = {in_byte[6:0], ident_r[6:0]};
          state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        if (acc) begin
          if (in_byte == SYSEX_TERM) begin
            idx_nxt   = '0;
            state_nxt = (count_r == '0) ? ST_IDLE : ST_EMIT_RD;
          end else if (count_r < CW'(PAYLOAD_DEPTH)) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ST_EMIT_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        push.valid = 1'b1;
        push.data  = rd_data;
        push.last  = emit_last;
        push.trunc = ovf_r;
        if (out_free) begin
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire
